// File: hw/rtl/lfbf_pkg.sv
// shared types, constants and helpers for the least-frequent byte finder
// no dependencies; compiled first

package lfbf_pkg;

    localparam int DATA_WIDTH      = 8;
    localparam int NUM_VALUES      = 256;
    localparam int SEG_SIZE        = 64;
    localparam int NUM_SEGS        = 4;
    localparam int SEG_WIDTH       = 2;
    localparam int MIN_COUNT_WIDTH = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [DATA_WIDTH-1:0] TAB_CODE   = 8'd9;
    localparam logic [DATA_WIDTH-1:0] CR_CODE    = 8'd13;
    localparam logic [DATA_WIDTH-1:0] SPACE_CODE = 8'd32;

    localparam logic [SEG_WIDTH-1:0]  LAST_SEG   = 2'd3;

    // control from the sequencer to the count store
    typedef struct packed {
        logic                  upd;    // count one byte at addr
        logic                  scan;   // plain read of addr for the report walk
        logic                  clear;  // drop all counts back to zero
        logic [DATA_WIDTH-1:0] addr;
    } hist_req_t;

    // whitespace as formatted extraction sees it
    function automatic logic is_space(input logic [DATA_WIDTH-1:0] b);
        logic r;
        r = ((b >= TAB_CODE) && (b <= CR_CODE)) || (b == SPACE_CODE);
        return r;
    endfunction

endpackage

// File: hw/rtl/lfbf_if.sv
// channel interfaces: byte input, report output and configuration write
// depends on lfbf_pkg

interface lfbf_in_if import lfbf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] data_byte;
    logic                  end_marker;

    modport source (output valid, output data_byte, output end_marker, input ready);
    modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

interface lfbf_out_if import lfbf_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [SEG_WIDTH-1:0]       segment_index;
    logic [SEG_SIZE-1:0]        char_mask;
    logic [MIN_COUNT_WIDTH-1:0] min_count;
    logic                       any_seen;
    logic                       last_result;

    modport source (output valid, output segment_index, output char_mask,
                    output min_count, output any_seen, output last_result,
                    input ready);
    modport sink   (input valid, input segment_index, input char_mask,
                    input min_count, input any_seen, input last_result,
                    output ready);
endinterface

interface lfbf_cfg_if;
    logic valid;
    logic ready;
    logic skip_whitespace;

    modport source (output valid, output skip_whitespace, input ready);
    modport sink   (input valid, input skip_whitespace, output ready);
endinterface

// File: hw/rtl/lfbf_hist.sv
// byte count store: one synchronous ram with a read-modify-write increment path
// depends on lfbf_pkg

module lfbf_hist
    import lfbf_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hist_req_t              req,
    output logic [COUNT_WIDTH-1:0] rsp_count
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] mem [NUM_VALUES];
    logic [NUM_VALUES-1:0]  valid_bits_reg;

    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_vld_reg;
    logic                   upd_pend_reg;
    logic [DATA_WIDTH-1:0]  upd_addr_reg;
    logic                   wr_pend_reg;
    logic [DATA_WIDTH-1:0]  wr_addr_reg;
    logic [COUNT_WIDTH-1:0] wr_data_reg;

    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic                   rd_en;

    assign rd_en = req.upd || req.scan;

    // entry never written since the last clear reads as zero
    assign rsp_count = rd_vld_reg ? rd_data_reg : '0;

    // forward the write of the previous cycle, the ram read missed it
    assign cur_count = (wr_pend_reg && (wr_addr_reg == upd_addr_reg)) ? wr_data_reg
                                                                      : rsp_count;
    assign new_count = (cur_count == COUNT_MAX) ? cur_count
                                                : cur_count + COUNT_WIDTH'(1);

    // count ram, read data registered
    always_ff @(posedge clk)
    begin
        if (upd_pend_reg)
        begin
            mem[upd_addr_reg] <= new_count;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    // valid bits, update pipeline and forwarding registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= '0;
            rd_vld_reg     <= 1'b0;
            upd_pend_reg   <= 1'b0;
            upd_addr_reg   <= '0;
            wr_pend_reg    <= 1'b0;
            wr_addr_reg    <= '0;
            wr_data_reg    <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= valid_bits_reg[req.addr];
            end
            if (req.clear)
            begin
                valid_bits_reg <= '0;
            end
            else if (upd_pend_reg)
            begin
                valid_bits_reg[upd_addr_reg] <= 1'b1;
            end
            upd_pend_reg <= req.upd;
            upd_addr_reg <= req.addr;
            wr_pend_reg  <= upd_pend_reg;
            if (upd_pend_reg)
            begin
                wr_addr_reg <= upd_addr_reg;
                wr_data_reg <= new_count;
            end
        end
    end

endmodule

// File: hw/rtl/least_frequent_byte_finder_top.sv
// top level of the least-frequent byte finder: report sequencer and output register
// depends on lfbf_pkg, lfbf_if and lfbf_hist

// Takes one byte per cycle, with no gaps needed between bytes: each byte is a
// read-modify-write of a 256-entry count ram with one read port, and a byte that
// hits the same value as the byte before it picks up the forwarded count. An end
// marker stops intake until the report is out: a drain state, then a walk of the
// ram for the smallest nonzero count, then four passes that rebuild each 64-bit
// mask and hand it to the output register, each waiting while the report side
// stalls. The four reports come out in segment order; the counts are zero again
// as the last one is loaded, with no clearing pass. Counts saturate at
// 2^COUNT_WIDTH-1; min_count saturates at 65535. skip_whitespace resets to 1;
// the user writes it only while the block is idle; the block does not check this.

module least_frequent_byte_finder_top
    import lfbf_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    lfbf_in_if.sink    bytes,
    lfbf_out_if.source report,
    lfbf_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        S_RUN,
        S_DRAIN,
        S_MIN,
        S_MASK,
        S_EMIT
    } state_t;

    state_t                     state_reg;
    logic                       skip_reg;
    logic [DATA_WIDTH-1:0]      rd_idx_reg;
    logic                       issued_all_reg;
    logic                       rsp_valid_reg;
    logic [DATA_WIDTH-1:0]      rsp_idx_reg;
    logic [COUNT_WIDTH-1:0]     min_reg;
    logic                       seen_reg;
    logic [SEG_SIZE-1:0]        mask_reg;

    logic                       out_valid_reg;
    logic [SEG_WIDTH-1:0]       out_seg_reg;
    logic [SEG_SIZE-1:0]        out_mask_reg;
    logic [MIN_COUNT_WIDTH-1:0] out_min_reg;
    logic                       out_seen_reg;
    logic                       out_last_reg;

    hist_req_t                  req;
    logic [COUNT_WIDTH-1:0]     rsp_count;
    logic                       byte_xfer;
    logic                       out_free;
    logic [SEG_WIDTH-1:0]       rsp_seg;
    logic [31:0]                min_wide;
    logic [MIN_COUNT_WIDTH-1:0] min_sat;

    lfbf_hist #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_count (rsp_count)
    );

    // handshakes
    assign bytes.ready = (state_reg == S_RUN);
    assign cfg.ready   = 1'b1;
    assign byte_xfer   = bytes.valid && bytes.ready;
    assign out_free    = !out_valid_reg || report.ready;

    assign rsp_seg  = rsp_idx_reg[DATA_WIDTH-1 -: SEG_WIDTH];
    assign min_wide = 32'(min_reg);
    assign min_sat  = (min_wide > 32'(16'hFFFF)) ? 16'hFFFF
                                                 : min_wide[MIN_COUNT_WIDTH-1:0];

    // count store requests
    always_comb
    begin
        req.upd   = byte_xfer && !bytes.end_marker
                    && !(skip_reg && is_space(bytes.data_byte));
        req.scan  = ((state_reg == S_MIN) || (state_reg == S_MASK)) && !issued_all_reg;
        req.clear = (state_reg == S_EMIT) && out_free && (rsp_seg == LAST_SEG);
        req.addr  = req.scan ? rd_idx_reg : bytes.data_byte;
    end

    // report output
    assign report.valid         = out_valid_reg;
    assign report.segment_index = out_seg_reg;
    assign report.char_mask     = out_mask_reg;
    assign report.min_count     = out_min_reg;
    assign report.any_seen      = out_seen_reg;
    assign report.last_result   = out_last_reg;

    // sequencer, scan bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RUN;
            skip_reg       <= 1'b1;
            rd_idx_reg     <= '0;
            issued_all_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_idx_reg    <= '0;
            min_reg        <= '0;
            seen_reg       <= 1'b0;
            mask_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_seg_reg    <= '0;
            out_mask_reg   <= '0;
            out_min_reg    <= '0;
            out_seen_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // configuration transfer
            if (cfg.valid && cfg.ready)
            begin
                skip_reg <= cfg.skip_whitespace;
            end

            // output register drains on transfer, unless a segment is loaded behind it
            if (report.valid && report.ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            // walk address and response tag
            rsp_valid_reg <= req.scan;
            if (req.scan)
            begin
                rsp_idx_reg <= rd_idx_reg;
                rd_idx_reg  <= rd_idx_reg + DATA_WIDTH'(1);
            end

            case (state_reg)
                S_RUN:
                begin
                    if (byte_xfer && bytes.end_marker)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end

                // last byte count is already in the ram by this state
                S_DRAIN:
                begin
                    min_reg        <= '0;
                    seen_reg       <= 1'b0;
                    mask_reg       <= '0;
                    issued_all_reg <= 1'b0;
                    state_reg      <= S_MIN;
                end

                // smallest nonzero count over all entries
                S_MIN:
                begin
                    if (req.scan && (rd_idx_reg == {DATA_WIDTH{1'b1}}))
                    begin
                        issued_all_reg <= 1'b1;
                    end
                    if (rsp_valid_reg)
                    begin
                        if ((rsp_count != '0) && (!seen_reg || (rsp_count < min_reg)))
                        begin
                            min_reg  <= rsp_count;
                            seen_reg <= 1'b1;
                        end
                        if (rsp_idx_reg == {DATA_WIDTH{1'b1}})
                        begin
                            issued_all_reg <= 1'b0;
                            state_reg      <= S_MASK;
                        end
                    end
                end

                // one segment of the mask
                S_MASK:
                begin
                    if (req.scan && (rd_idx_reg[5:0] == 6'h3F))
                    begin
                        issued_all_reg <= 1'b1;
                    end
                    if (rsp_valid_reg)
                    begin
                        if (seen_reg && (rsp_count == min_reg))
                        begin
                            mask_reg[rsp_idx_reg[5:0]] <= 1'b1;
                        end
                        if (rsp_idx_reg[5:0] == 6'h3F)
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end

                // hand the segment to the output register
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_seg_reg    <= rsp_seg;
                        out_mask_reg   <= mask_reg;
                        out_min_reg    <= min_sat;
                        out_seen_reg   <= seen_reg;
                        out_last_reg   <= (rsp_seg == LAST_SEG);
                        mask_reg       <= '0;
                        issued_all_reg <= 1'b0;
                        if (rsp_seg == LAST_SEG)
                        begin
                            state_reg <= S_RUN;
                        end
                        else
                        begin
                            state_reg <= S_MASK;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

endmodule
